// ===== sv/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TRIGGER_W  = 24;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 2'd1;

    localparam logic [TRIGGER_W-1:0] TRIGGER_TICKS_RST = 24'd1000;
    localparam logic [SCALE_W-1:0]   SCALE_Q16_RST     = 16'd2802;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic              trigger_out;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_mm;
    } out_item_t;

endpackage

// ===== sv/uer_if.sv =====
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels for timer ticks and per-tick results.
// ----------------------------------------------------------------------------
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_report_if;
    logic        valid;
    logic        ready;
    logic        trigger_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] distance_mm;

    modport source (output valid, output trigger_out, output busy_res, output done_res,
                    output distance_mm, input ready);
    modport sink   (input valid, input trigger_out, input busy_res, input done_res,
                    input distance_mm, output ready);
endinterface

// ===== sv/uer_dist.sv =====
// ----------------------------------------------------------------------------
// uer_dist
// Single echo distance: (pulse >> 1) * scale >> 16, saturated to 16 bits.
// ----------------------------------------------------------------------------
module uer_dist #(
    parameter int PULSE_WIDTH_BITS = 24
) (
    input  logic [PULSE_WIDTH_BITS-1:0] pulse_ticks,
    input  logic [uer_pkg::SCALE_W-1:0] scale_q16,
    output logic [uer_pkg::DIST_W-1:0]  distance
);
    import uer_pkg::*;

    localparam int QW = PULSE_WIDTH_BITS - 1;
    localparam int PW = QW + SCALE_W;

    logic [PW-1:0] prod;
    logic [QW-1:0] quot;
    logic [31:0]   quot_wide;

    always_comb
    begin
        prod      = PW'(pulse_ticks[PULSE_WIDTH_BITS-1:1]) * PW'(scale_q16);
        quot      = prod[PW-1:SCALE_W];
        quot_wide = 32'(quot);
        distance  = (quot_wide > 32'h0000_FFFF) ? 16'hFFFF : quot_wide[DIST_W-1:0];
    end

endmodule

// ===== sv/uer_core.sv =====
// ----------------------------------------------------------------------------
// uer_core
// Measurement sequencer: trigger, echo wait, pulse count and averaging.
// ----------------------------------------------------------------------------
module uer_core #(
    parameter int PULSE_WIDTH_BITS = 24,
    parameter int AVERAGE_LOG2     = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  uer_pkg::in_item_t             item,
    input  logic [uer_pkg::TRIGGER_W-1:0] trigger_ticks,
    input  logic [uer_pkg::SCALE_W-1:0]   scale_q16,
    output uer_pkg::out_item_t            res
);
    import uer_pkg::*;

    localparam int SUM_W        = DIST_W + AVERAGE_LOG2;
    localparam int CNT_W        = AVERAGE_LOG2 + 1;
    localparam int SAMPLE_COUNT = 1 << AVERAGE_LOG2;

    phase_t                      phase_reg, phase_next;
    logic                        prev_echo_reg;
    logic [TRIGGER_W-1:0]        trigger_count_reg, trigger_count_next;
    logic [PULSE_WIDTH_BITS-1:0] pulse_ticks_reg, pulse_ticks_next;
    logic [CNT_W-1:0]            sample_index_reg, sample_index_next;
    logic [SUM_W-1:0]            distance_sum_reg, distance_sum_next;
    logic [DIST_W-1:0]           distance;
    logic [CNT_W-1:0]            sample_inc;
    logic [SUM_W-1:0]            sum_inc;

    uer_dist #(
        .PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)
    ) u_dist (
        .pulse_ticks(pulse_ticks_reg),
        .scale_q16  (scale_q16),
        .distance   (distance)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            prev_echo_reg     <= 1'b0;
            trigger_count_reg <= '0;
            pulse_ticks_reg   <= '0;
            sample_index_reg  <= '0;
            distance_sum_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            prev_echo_reg     <= item.echo_level;
            trigger_count_reg <= trigger_count_next;
            pulse_ticks_reg   <= pulse_ticks_next;
            sample_index_reg  <= sample_index_next;
            distance_sum_reg  <= distance_sum_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        trigger_count_next = trigger_count_reg;
        pulse_ticks_next   = pulse_ticks_reg;
        sample_index_next  = sample_index_reg;
        distance_sum_next  = distance_sum_reg;
        sample_inc         = sample_index_reg + 1'b1;
        sum_inc            = distance_sum_reg + SUM_W'(distance);
        res                = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    sample_index_next  = '0;
                    distance_sum_next  = '0;
                    trigger_count_next = TRIGGER_W'(1);
                    phase_next         = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                if (trigger_count_reg >= trigger_ticks)
                    phase_next = PH_WAIT;
                else
                    trigger_count_next = trigger_count_reg + 1'b1;
            end
            PH_WAIT:
            begin
                if (item.echo_level && !prev_echo_reg)
                begin
                    pulse_ticks_next = PULSE_WIDTH_BITS'(1);
                    phase_next       = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                if (item.echo_level)
                begin
                    if (pulse_ticks_reg != '1)
                        pulse_ticks_next = pulse_ticks_reg + 1'b1;
                end
                else
                begin
                    distance_sum_next = sum_inc;
                    sample_index_next = sample_inc;
                    if (sample_inc == CNT_W'(SAMPLE_COUNT))
                    begin
                        res.done_res    = 1'b1;
                        res.distance_mm = DIST_W'(sum_inc >> AVERAGE_LOG2);
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        trigger_count_next = TRIGGER_W'(1);
                        phase_next         = PH_TRIG;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res.trigger_out = (phase_next == PH_TRIG);
        res.busy_res    = (phase_next != PH_IDLE);
    end

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    a_meas_pulse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MEAS |-> pulse_ticks_reg != '0)
        else $error("measuring with empty pulse count");

    a_trig_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRIG |-> trigger_count_reg != '0)
        else $error("trigger count is zero in trigger phase");

    a_hold_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(distance_sum_reg))
        else $error("state moved without a tick");
`endif

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Averaged ultrasonic ranging from echo pulse widths, one timer tick per beat.
// ----------------------------------------------------------------------------
// Each tick beat carries a start request and the sampled echo level; each
// produces exactly one report beat with the trigger level, busy, done and the
// mean distance in millimetres. A tick beat is taken every clock cycle when
// the report side keeps up; a report passes from its tick through the input
// register and then the result register, and the sequencer state advances
// once per tick in a single pass that holds the distance multiplier and the
// sum adder.
module ultrasonic_echo_ranger #(
    parameter int PULSE_WIDTH_BITS = 24,
    parameter int AVERAGE_LOG2     = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    uer_tick_if.sink                       tick,
    uer_report_if.source                   report,
    input  logic                           cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uer_pkg::*;

    logic                 hold_valid_reg;
    in_item_t             hold_item_reg;
    logic                 res_valid_reg;
    out_item_t            res_item_reg;
    out_item_t            res;
    logic                 advance;
    logic [TRIGGER_W-1:0] trigger_ticks_reg;
    logic [SCALE_W-1:0]   scale_q16_reg;

    assign advance    = hold_valid_reg && (!res_valid_reg || report.ready);
    assign tick.ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            scale_q16_reg     <= SCALE_Q16_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[TRIGGER_W-1:0];
                CFG_SCALE_Q16:     scale_q16_reg     <= cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (tick.ready)
            hold_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            hold_item_reg.start_req  <= tick.start_req;
            hold_item_reg.echo_level <= tick.echo_level;
        end
    end

    uer_core #(
        .PULSE_WIDTH_BITS(PULSE_WIDTH_BITS),
        .AVERAGE_LOG2    (AVERAGE_LOG2)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (hold_item_reg),
        .trigger_ticks(trigger_ticks_reg),
        .scale_q16    (scale_q16_reg),
        .res          (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (report.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_item_reg <= res;
    end

    assign report.valid       = res_valid_reg;
    assign report.trigger_out = res_item_reg.trigger_out;
    assign report.busy_res    = res_item_reg.busy_res;
    assign report.done_res    = res_item_reg.done_res;
    assign report.distance_mm = res_item_reg.distance_mm;

endmodule
